>>> src/rcbv_pkg.sv
// ----------------------------------------------------------------------------
// rcbv_pkg
// Shared types and constants for the rod-cutting best value solver.
// ----------------------------------------------------------------------------
package rcbv_pkg;

   localparam int MAX_PIECES = 16;
   localparam int MAX_LENGTH = 1023;

   localparam int IDX_W  = 4;   // piece table index
   localparam int CNT_W  = 5;   // piece count, holds MAX_PIECES itself
   localparam int LEN_W  = 10;  // lengths and best table address
   localparam int VAL_W  = 16;  // piece price
   localparam int BEST_W = 32;  // best table entry

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_SOLVE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FINISH
   } state_type;

endpackage

>>> src/rod_cutting_best_value_top.sv
// ----------------------------------------------------------------------------
// rod_cutting_best_value_top
// Rod-cutting dynamic program: one shared add/compare unit walks every
// length and every piece in use, filling a 1024-entry best table.
// ----------------------------------------------------------------------------
// Solve: a solve for total T with n pieces in use (count clamped to 16) walks
//   lengths 1 to T; for T of 0 the result is strobed in the cycle after the transfer.
//   The add/compare unit takes one piece per cycle, then stores best[j] for each length.
// Throughput: one solve at a time, busy high until the result cycle.
//   A piece write never raises busy.
// Reset: synchronous, clears the sequencer, piece count and result strobe;
//   tables are undefined until written. The receiver cannot stall results.
module rod_cutting_best_value_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [rcbv_pkg::IDX_W-1:0]  req_piece_index,
   input  logic [rcbv_pkg::LEN_W-1:0]  req_piece_length,
   input  logic [rcbv_pkg::VAL_W-1:0]  req_piece_value,
   input  logic [rcbv_pkg::LEN_W-1:0]  req_total_length,
   output logic                        rsp_valid,
   output logic [rcbv_pkg::BEST_W-1:0] rsp_best_value,
   input  logic                        csr_wr_en,
   input  logic [rcbv_pkg::CNT_W-1:0]  csr_wr_data
);

   localparam int BEST_DEPTH = rcbv_pkg::MAX_LENGTH + 1;

   // piece table (small register file, one read address) and best table
   logic [rcbv_pkg::LEN_W-1:0]  len_mem  [rcbv_pkg::MAX_PIECES];
   logic [rcbv_pkg::VAL_W-1:0]  val_mem  [rcbv_pkg::MAX_PIECES];
   logic [rcbv_pkg::BEST_W-1:0] best_mem [BEST_DEPTH];

   rcbv_pkg::state_type state_ff, state_in;

   logic [rcbv_pkg::CNT_W-1:0]  piece_count_ff;
   logic [rcbv_pkg::CNT_W-1:0]  used_ff, used_in, used_clamp;
   logic [rcbv_pkg::CNT_W-1:0]  p_ff, p_in;
   logic [rcbv_pkg::LEN_W-1:0]  j_ff, j_in;
   logic [rcbv_pkg::LEN_W-1:0]  total_ff, total_in, total_clamp;
   logic [rcbv_pkg::BEST_W-1:0] top_ff, top_in, top_next;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_zero_ff, s1_zero_in;
   logic [rcbv_pkg::VAL_W-1:0]  s1_value_ff, s1_value_in;
   logic [rcbv_pkg::BEST_W-1:0] rd_data_ff;
   logic [rcbv_pkg::LEN_W-1:0]  rd_addr;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rcbv_pkg::BEST_W-1:0] rsp_best_value_ff, rsp_best_value_in;

   logic                        accept, solve_go, write_go, best_we;
   logic [rcbv_pkg::LEN_W-1:0]  cur_len;
   logic [rcbv_pkg::BEST_W:0]   sum;
   logic [rcbv_pkg::BEST_W-1:0] cand;

   assign accept   = start && (state_ff == rcbv_pkg::ST_IDLE);
   assign solve_go = accept && (req_mode == rcbv_pkg::MODE_SOLVE);
   assign write_go = accept && (req_mode == rcbv_pkg::MODE_WRITE);
   assign busy     = (state_ff != rcbv_pkg::ST_IDLE);

   assign used_clamp = (piece_count_ff > rcbv_pkg::CNT_W'(rcbv_pkg::MAX_PIECES)) ?
                       rcbv_pkg::CNT_W'(rcbv_pkg::MAX_PIECES) : piece_count_ff;
   assign total_clamp = (req_total_length > rcbv_pkg::LEN_W'(rcbv_pkg::MAX_LENGTH)) ?
                        rcbv_pkg::LEN_W'(rcbv_pkg::MAX_LENGTH) : req_total_length;

   // shared unit: saturating add of the previous issue's price and best entry
   assign cur_len  = len_mem[p_ff[rcbv_pkg::IDX_W-1:0]];
   assign sum      = {1'b0, (s1_zero_ff ? {rcbv_pkg::BEST_W{1'b0}} : rd_data_ff)}
                   + {{(rcbv_pkg::BEST_W - rcbv_pkg::VAL_W + 1){1'b0}}, s1_value_ff};
   assign cand     = sum[rcbv_pkg::BEST_W] ? '1 : sum[rcbv_pkg::BEST_W-1:0];
   assign top_next = (s1_valid_ff && (cand > top_ff)) ? cand : top_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcbv_pkg::ST_IDLE: begin
            if (solve_go && (total_clamp != '0)) begin
               state_in = (used_clamp == '0) ? rcbv_pkg::ST_FINISH : rcbv_pkg::ST_ISSUE;
            end
         end
         rcbv_pkg::ST_ISSUE: begin
            if (p_ff + 1'b1 == used_ff) begin
               state_in = rcbv_pkg::ST_FINISH;
            end
         end
         rcbv_pkg::ST_FINISH: begin
            if (j_ff == total_ff) begin
               state_in = rcbv_pkg::ST_IDLE;
            end else begin
               state_in = (used_ff == '0) ? rcbv_pkg::ST_FINISH : rcbv_pkg::ST_ISSUE;
            end
         end
         default: state_in = rcbv_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      used_in           = used_ff;
      total_in          = total_ff;
      p_in              = p_ff;
      j_in              = j_ff;
      top_in            = top_ff;
      s1_valid_in       = 1'b0;
      s1_zero_in        = 1'b0;
      s1_value_in       = s1_value_ff;
      rd_addr           = j_ff - cur_len;
      best_we           = 1'b0;
      rsp_valid_in      = 1'b0;
      rsp_best_value_in = rsp_best_value_ff;
      unique case (state_ff)
         rcbv_pkg::ST_IDLE: begin
            if (solve_go) begin
               used_in  = used_clamp;
               total_in = total_clamp;
               p_in     = '0;
               j_in     = rcbv_pkg::LEN_W'(1);
               top_in   = '0;
               if (total_clamp == '0) begin
                  rsp_valid_in      = 1'b1;
                  rsp_best_value_in = '0;
               end
            end
         end
         rcbv_pkg::ST_ISSUE: begin
            p_in        = p_ff + 1'b1;
            top_in      = top_next;
            s1_valid_in = (cur_len != '0) && (cur_len <= j_ff);
            s1_zero_in  = (cur_len == j_ff);
            s1_value_in = val_mem[p_ff[rcbv_pkg::IDX_W-1:0]];
         end
         rcbv_pkg::ST_FINISH: begin
            best_we = 1'b1;
            p_in    = '0;
            j_in    = j_ff + 1'b1;
            top_in  = '0;
            if (j_ff == total_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_best_value_in = top_next;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rcbv_pkg::ST_IDLE;
         piece_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
         if (csr_wr_en) begin
            piece_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      used_ff           <= used_in;
      total_ff          <= total_in;
      p_ff              <= p_in;
      j_ff              <= j_in;
      top_ff            <= top_in;
      s1_zero_ff        <= s1_zero_in;
      s1_value_ff       <= s1_value_in;
      rsp_best_value_ff <= rsp_best_value_in;
   end

   always_ff @(posedge clock) begin
      if (write_go) begin
         len_mem[req_piece_index] <= req_piece_length;
         val_mem[req_piece_index] <= req_piece_value;
      end
   end

   // best table: one write, one registered read
   always_ff @(posedge clock) begin
      if (best_we) begin
         best_mem[j_ff] <= top_next;
      end
      rd_data_ff <= best_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_value = rsp_best_value_ff;

   // busy only drops on the cycle the result is strobed
   a_busy_drop: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (j_ff != '0) && (j_ff <= total_ff))
      else $error("length counter out of range");

   a_piece_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcbv_pkg::ST_ISSUE) |-> (p_ff < used_ff))
      else $error("piece counter past pieces in use");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rod_cutting_best_value_top. Piece writes and solves
// are queued per phase and driven with random gaps; a local dynamic program
// works out each best value as the solve transfer happens, and every result
// strobe is checked against the oldest outstanding answer. The piece count
// register is only changed while the block is quiet.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic                       mode;
      logic [rcbv_pkg::IDX_W-1:0] slot;
      logic [rcbv_pkg::LEN_W-1:0] length;
      logic [rcbv_pkg::VAL_W-1:0] price;
      logic [rcbv_pkg::LEN_W-1:0] total;
   } rod_req_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_mode = rcbv_pkg::MODE_WRITE;
   logic [rcbv_pkg::IDX_W-1:0]  req_piece_index = '0;
   logic [rcbv_pkg::LEN_W-1:0]  req_piece_length = '0;
   logic [rcbv_pkg::VAL_W-1:0]  req_piece_value = '0;
   logic [rcbv_pkg::LEN_W-1:0]  req_total_length = '0;
   logic                        rsp_valid;
   logic [rcbv_pkg::BEST_W-1:0] rsp_best_value;
   logic                        csr_wr_en = 1'b0;
   logic [rcbv_pkg::CNT_W-1:0]  csr_wr_data = '0;

   // local copy of the block's tables
   logic [rcbv_pkg::LEN_W-1:0]  length_table [0:rcbv_pkg::MAX_PIECES-1];
   logic [rcbv_pkg::VAL_W-1:0]  price_table [0:rcbv_pkg::MAX_PIECES-1];
   logic [rcbv_pkg::BEST_W-1:0] best_so_far [0:rcbv_pkg::MAX_LENGTH];
   logic [rcbv_pkg::CNT_W-1:0]  pieces_in_use = '0;

   rod_req_type                 pending [$];
   logic [rcbv_pkg::BEST_W-1:0] best_values_due [$];
   rod_req_type                 cur;
   logic [rcbv_pkg::BEST_W-1:0] due_value;
   logic                        taken = 1'b0;
   logic                        holding = 1'b0;
   logic                        steady = 1'b0;
   int                          gap_left = 0;
   int                          faults = 0;
   int                          writes_taken = 0;
   int                          solves_taken = 0;
   int                          solves_checked = 0;
   int                          longest_rod = 0;
   int                          count_lo = 31;
   int                          count_hi = 0;

   rod_cutting_best_value_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_piece_index  (req_piece_index),
      .req_piece_length (req_piece_length),
      .req_piece_value  (req_piece_value),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_best_value   (rsp_best_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // bottom-up rebuild of the best table, saturating sums
   function automatic logic [rcbv_pkg::BEST_W-1:0] solve_rod(
         input logic [rcbv_pkg::LEN_W-1:0] total);
      int                          used;
      int                          j;
      int                          p;
      logic [rcbv_pkg::BEST_W-1:0] top;
      logic [rcbv_pkg::BEST_W-1:0] cand;
      logic [rcbv_pkg::BEST_W:0]   sum;
      used = (pieces_in_use > rcbv_pkg::MAX_PIECES) ? rcbv_pkg::MAX_PIECES
                                                     : int'(pieces_in_use);
      best_so_far[0] = '0;
      for (j = 1; j <= int'(total); j++) begin
         top = '0;
         for (p = 0; p < used; p++) begin
            if (length_table[p] != 0 && int'(length_table[p]) <= j) begin
               sum = (rcbv_pkg::BEST_W + 1)'(price_table[p])
                   + (rcbv_pkg::BEST_W + 1)'(best_so_far[j - int'(length_table[p])]);
               cand = sum[rcbv_pkg::BEST_W] ? '1 : sum[rcbv_pkg::BEST_W-1:0];
               if (cand > top) top = cand;
            end
         end
         best_so_far[j] = top;
      end
      return best_so_far[total];
   endfunction

   function automatic rod_req_type piece_write(input logic [rcbv_pkg::IDX_W-1:0] slot,
                                               input logic [rcbv_pkg::LEN_W-1:0] length,
                                               input logic [rcbv_pkg::VAL_W-1:0] price);
      rod_req_type r;
      r.mode   = rcbv_pkg::MODE_WRITE;
      r.slot   = slot;
      r.length = length;
      r.price  = price;
      r.total  = rcbv_pkg::LEN_W'($urandom_range(0, rcbv_pkg::MAX_LENGTH));
      return r;
   endfunction

   function automatic rod_req_type rod_solve(input logic [rcbv_pkg::LEN_W-1:0] total);
      rod_req_type r;
      r.mode   = rcbv_pkg::MODE_SOLVE;
      r.slot   = rcbv_pkg::IDX_W'($urandom_range(0, rcbv_pkg::MAX_PIECES - 1));
      r.length = rcbv_pkg::LEN_W'($urandom_range(0, rcbv_pkg::MAX_LENGTH));
      r.price  = rcbv_pkg::VAL_W'($urandom_range(0, 65535));
      r.total  = total;
      return r;
   endfunction

   task automatic report_fault(input string what,
                               input logic [rcbv_pkg::BEST_W-1:0] want,
                               input logic [rcbv_pkg::BEST_W-1:0] got);
      faults++;
      if (faults <= 10)
         $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic wait_quiet();
      while (pending.size() != 0 || holding || best_values_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_piece_count(input logic [rcbv_pkg::CNT_W-1:0] n);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= rcbv_pkg::CNT_W'($urandom_range(0, 31));
      pieces_in_use = n;
      if (int'(n) < count_lo) count_lo = int'(n);
      if (int'(n) > count_hi) count_hi = int'(n);
   endtask

   // request side: a transfer is taken at a rising edge with start and not busy
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         taken = 1'b1;
         if (req_mode == rcbv_pkg::MODE_WRITE) begin
            length_table[req_piece_index] = req_piece_length;
            price_table[req_piece_index]  = req_piece_value;
            writes_taken++;
         end else begin
            best_values_due.push_back(solve_rod(req_total_length));
            solves_taken++;
            if (int'(req_total_length) > longest_rod) longest_rod = int'(req_total_length);
         end
      end
   end

   // result side: the strobe lasts one cycle and cannot be held off
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (best_values_due.size() == 0) begin
            report_fault("unrequested result", '0, rsp_best_value);
         end else begin
            due_value = best_values_due.pop_front();
            solves_checked++;
            if (rsp_best_value !== due_value)
               report_fault("best_value", due_value, rsp_best_value);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            taken   = 1'b0;
            holding = 1'b0;
            if ($urandom_range(0, 11) == 0) steady = ~steady;
            gap_left = steady ? 0 : int'($urandom_range(0, 7));
         end
         // gaps only count down once the block has finished with a solve
         if (!holding && gap_left != 0) begin
            if (!busy) gap_left--;
         end else if (!holding && pending.size() != 0) begin
            cur     = pending.pop_front();
            holding = 1'b1;
         end
         start <= holding;
         if (holding) begin
            req_mode         <= cur.mode;
            req_piece_index  <= cur.slot;
            req_piece_length <= cur.length;
            req_piece_value  <= cur.price;
            req_total_length <= cur.total;
         end else begin
            req_mode         <= 1'($urandom_range(0, 1));
            req_piece_index  <= rcbv_pkg::IDX_W'($urandom_range(0, rcbv_pkg::MAX_PIECES - 1));
            req_piece_length <= rcbv_pkg::LEN_W'($urandom_range(0, rcbv_pkg::MAX_LENGTH));
            req_piece_value  <= rcbv_pkg::VAL_W'($urandom_range(0, 65535));
            req_total_length <= rcbv_pkg::LEN_W'($urandom_range(0, rcbv_pkg::MAX_LENGTH));
         end
      end
   end

   initial begin
      int                         k;
      int                         phase;
      int                         big_left;
      logic [rcbv_pkg::CNT_W-1:0] cnt;
      logic [rcbv_pkg::LEN_W-1:0] len;
      logic [rcbv_pkg::LEN_W-1:0] tot;
      for (k = 0; k < rcbv_pkg::MAX_PIECES; k++) begin
         length_table[k] = '0;
         price_table[k]  = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no pieces in use yet: every answer is zero
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(0)));
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(rcbv_pkg::MAX_LENGTH)));
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(5)));
      // fill the whole table before any count lets it be read
      pending.push_back(piece_write(rcbv_pkg::IDX_W'(0), rcbv_pkg::LEN_W'(1),
                                    rcbv_pkg::VAL_W'(1)));
      pending.push_back(piece_write(rcbv_pkg::IDX_W'(1), rcbv_pkg::LEN_W'(2),
                                    rcbv_pkg::VAL_W'(0)));
      pending.push_back(piece_write(rcbv_pkg::IDX_W'(2), rcbv_pkg::LEN_W'(3), 16'hFFFF));
      // zero length, never used
      pending.push_back(piece_write(rcbv_pkg::IDX_W'(3), rcbv_pkg::LEN_W'(0), 16'hFFFF));
      for (k = 4; k < rcbv_pkg::MAX_PIECES - 1; k++)
         pending.push_back(piece_write(rcbv_pkg::IDX_W'(k),
                                       rcbv_pkg::LEN_W'($urandom_range(2, 24)),
                                       rcbv_pkg::VAL_W'($urandom_range(0, 65535))));
      pending.push_back(piece_write(rcbv_pkg::IDX_W'(rcbv_pkg::MAX_PIECES - 1),
                                    rcbv_pkg::LEN_W'(rcbv_pkg::MAX_LENGTH), 16'hFFFF));
      wait_quiet();
      set_piece_count(rcbv_pkg::CNT_W'(rcbv_pkg::MAX_PIECES));
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(rcbv_pkg::MAX_LENGTH)));
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(1)));
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(2)));  // longer pieces cannot fit
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(3)));  // a whole uncut piece wins
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(0)));
      wait_quiet();
      set_piece_count(rcbv_pkg::CNT_W'(31));  // clamps to the table size
      pending.push_back(rod_solve(rcbv_pkg::LEN_W'(200)));
      wait_quiet();

      big_left = 4;
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            cnt = rcbv_pkg::CNT_W'($urandom_range(1, rcbv_pkg::MAX_PIECES));
         else if (phase == 5)
            cnt = rcbv_pkg::CNT_W'(rcbv_pkg::MAX_PIECES);
         else
            cnt = rcbv_pkg::CNT_W'($urandom_range(0, 31));
         set_piece_count(cnt);
         for (k = 0; k < 16; k++) begin
            if ($urandom_range(0, 9) < 4) begin
               len = ($urandom_range(0, 9) == 0)
                   ? rcbv_pkg::LEN_W'($urandom_range(0, rcbv_pkg::MAX_LENGTH))
                   : rcbv_pkg::LEN_W'($urandom_range(1, 32));
               pending.push_back(piece_write(
                  rcbv_pkg::IDX_W'($urandom_range(0, rcbv_pkg::MAX_PIECES - 1)), len,
                  rcbv_pkg::VAL_W'($urandom_range(0, 65535))));
            end else begin
               // long rods are costly, so only a handful of them
               if (big_left > 0 && $urandom_range(0, 29) == 0) begin
                  big_left--;
                  tot = rcbv_pkg::LEN_W'($urandom_range(512, rcbv_pkg::MAX_LENGTH));
               end else begin
                  tot = rcbv_pkg::LEN_W'($urandom_range(0, 80));
               end
               pending.push_back(rod_solve(tot));
            end
         end
         wait_quiet();
      end

      repeat (50) @(negedge clock);
      $display("Run covered %0d writes and %0d solves, %0d results checked.",
               writes_taken, solves_taken, solves_checked);
      $display("Rod lengths up to %0d, piece counts set from %0d to %0d.",
               longest_rod, count_lo, count_hi);
      if (faults == 0 && best_values_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> rod_cutting_best_value_top.f
src/rcbv_pkg.sv
src/rod_cutting_best_value_top.sv
sim/testbench.sv
